// File: rtl/mmh3_pkg.sv
// Package for the MurmurHash3 x64 128-bit engine.
// Holds the word types, mixing constants, command and status structs and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package mmh3_pkg;

    // Input word: one 16-byte block of the message, little-endian.
    typedef struct packed {
        logic [63:0] bytes_low;
        logic [63:0] bytes_high;
        logic [4:0]  byte_count;
        logic        last;
    } in_word_t;

    // Output word: the two halves of the 128-bit hash.
    typedef struct packed {
        logic [63:0] hash_first;
        logic [63:0] hash_second;
    } out_word_t;

    // Mixing and finalizer constants.
    localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] FIN_M1  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_M2  = 64'hc4ceb9fe1a85ec53;

    // Constant pair selection for the two multiply units.
    localparam logic [1:0] MUL_KEY_A = 2'd0;  // lane one C1, lane two C2
    localparam logic [1:0] MUL_KEY_B = 2'd1;  // lane one C2, lane two C1
    localparam logic [1:0] MUL_FIN_A = 2'd2;  // both lanes FIN_M1
    localparam logic [1:0] MUL_FIN_B = 2'd3;  // both lanes FIN_M2

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul_issue;
        logic [1:0] mul_sel;
        logic       mul_write;
        logic       rot_keys;
        logic       mix_one;
        logic       scale_one;
        logic       mix_two;
        logic       scale_two;
        logic       tail_mix;
        logic       fold_len;
        logic       add_one;
        logic       add_two;
        logic       xs_lanes;
        logic       xs_keys;
        logic       sum_lanes;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic last;
    } stat_t;

    // Rotate a 64-bit word left by a fixed amount.
    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    // Keep the lowest n bytes of a word, n from 0 to 7.
    function automatic logic [63:0] low_bytes(input logic [63:0] x, input logic [2:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < n) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return x & m;
    endfunction

endpackage

// File: rtl/mmh3_datapath.sv
// Datapath of the MurmurHash3 x64 128-bit engine: lanes, keys, length, two multiply units.
// Acts only on commands from mmh3_ctrl; depends on mmh3_pkg.
`timescale 1ns / 1ps

module mmh3_datapath
    import mmh3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  in_word_t    in_word,
    input  cmd_t        cmd,
    output stat_t       stat,
    output out_word_t   out_word
);

    logic [63:0] seed_reg, seed_next;
    logic        start_reg, start_next;
    logic [31:0] len_reg, len_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] ka_reg, ka_next;
    logic [63:0] kb_reg, kb_next;
    logic        full_reg, full_next;
    logic        last_reg, last_next;
    logic [63:0] pll_a_reg, pll_b_reg;
    logic [31:0] plh_a_reg, phl_a_reg, plh_b_reg, phl_b_reg;
    logic [63:0] ca, cb;
    logic [63:0] prod_a, prod_b;
    logic [31:0] cnt_add;
    logic        in_full;
    logic [3:0]  tail_cnt;
    logic [63:0] tail_k1, tail_k2;
    out_word_t   out_reg, out_next;

    // Decode the incoming word: full block or masked tail, and its length step.
    always_comb begin
        in_full  = !in_word.last || in_word.byte_count[4];
        tail_cnt = in_word.byte_count[3:0];
        tail_k1  = tail_cnt[3] ? in_word.bytes_low : low_bytes(in_word.bytes_low, tail_cnt[2:0]);
        tail_k2  = tail_cnt[3] ? low_bytes(in_word.bytes_high, tail_cnt[2:0]) : 64'd0;
        if (in_full) begin
            cnt_add = 32'd16;
        end else begin
            cnt_add = {28'd0, tail_cnt};
        end
    end

    // Constant selection for the multiply units.
    always_comb begin
        case (cmd.mul_sel)
            MUL_KEY_A: begin
                ca = MIX_C1;
                cb = MIX_C2;
            end
            MUL_KEY_B: begin
                ca = MIX_C2;
                cb = MIX_C1;
            end
            MUL_FIN_A: begin
                ca = FIN_M1;
                cb = FIN_M1;
            end
            MUL_FIN_B: begin
                ca = FIN_M2;
                cb = FIN_M2;
            end
            default: begin
                ca = MIX_C1;
                cb = MIX_C2;
            end
        endcase
    end

    // Second multiply stage: combine the registered partial products (low 64 bits).
    assign prod_a = pll_a_reg + {plh_a_reg + phl_a_reg, 32'd0};
    assign prod_b = pll_b_reg + {plh_b_reg + phl_b_reg, 32'd0};

    // Next values for configuration, length and message flags.
    always_comb begin
        seed_next  = cfg_wr_en ? cfg_wr_data : seed_reg;
        start_next = start_reg;
        len_next   = len_reg;
        full_next  = full_reg;
        last_next  = last_reg;
        if (cmd.load) begin
            start_next = in_word.last;
            len_next   = (start_reg ? 32'd0 : len_reg) + cnt_add;
            full_next  = in_full;
            last_next  = in_word.last;
        end
    end

    // Key registers: loaded from the word, then multiplied, rotated or shift-xored.
    always_comb begin
        ka_next = ka_reg;
        kb_next = kb_reg;
        if (cmd.load) begin
            ka_next = in_full ? in_word.bytes_low  : tail_k1;
            kb_next = in_full ? in_word.bytes_high : tail_k2;
        end else if (cmd.mul_write) begin
            ka_next = prod_a;
            kb_next = prod_b;
        end else if (cmd.rot_keys) begin
            ka_next = rotl64(ka_reg, 6'd31);
            kb_next = rotl64(kb_reg, 6'd33);
        end else if (cmd.xs_lanes) begin
            ka_next = h1_reg ^ (h1_reg >> 33);
            kb_next = h2_reg ^ (h2_reg >> 33);
        end else if (cmd.xs_keys) begin
            ka_next = ka_reg ^ (ka_reg >> 33);
            kb_next = kb_reg ^ (kb_reg >> 33);
        end
    end

    // Lane registers: one recurrence step per cycle.
    always_comb begin
        h1_next = h1_reg;
        h2_next = h2_reg;
        if (cmd.load) begin
            if (start_reg) begin
                h1_next = seed_reg;
                h2_next = seed_reg;
            end
        end else if (cmd.mix_one) begin
            h1_next = rotl64(h1_reg ^ ka_reg, 6'd27) + h2_reg;
        end else if (cmd.scale_one) begin
            h1_next = (h1_reg << 2) + h1_reg + ADD_ONE;
        end else if (cmd.mix_two) begin
            h2_next = rotl64(h2_reg ^ kb_reg, 6'd31) + h1_reg;
        end else if (cmd.scale_two) begin
            h2_next = (h2_reg << 2) + h2_reg + ADD_TWO;
        end else if (cmd.tail_mix) begin
            h1_next = h1_reg ^ ka_reg;
            h2_next = h2_reg ^ kb_reg;
        end else if (cmd.fold_len) begin
            h1_next = h1_reg ^ {32'd0, len_reg};
            h2_next = h2_reg ^ {32'd0, len_reg};
        end else if (cmd.add_one) begin
            h1_next = h1_reg + h2_reg;
        end else if (cmd.add_two) begin
            h2_next = h2_reg + h1_reg;
        end else if (cmd.sum_lanes) begin
            h1_next = ka_reg + kb_reg;
        end
    end

    // Output word register: second half is the finalized lane two plus the new lane one.
    always_comb begin
        out_next = out_reg;
        if (cmd.out_load) begin
            out_next.hash_first  = h1_reg;
            out_next.hash_second = h1_reg + kb_reg;
        end
    end

    // Control-like registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= '0;
            start_reg <= 1'b1;
            len_reg   <= '0;
        end else begin
            seed_reg  <= seed_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    // Payload registers and the first multiply stage.
    always_ff @(posedge aclk) begin
        h1_reg   <= h1_next;
        h2_reg   <= h2_next;
        ka_reg   <= ka_next;
        kb_reg   <= kb_next;
        full_reg <= full_next;
        last_reg <= last_next;
        out_reg  <= out_next;
        if (cmd.mul_issue) begin
            pll_a_reg <= ka_reg[31:0] * ca[31:0];
            plh_a_reg <= ka_reg[31:0] * ca[63:32];
            phl_a_reg <= ka_reg[63:32] * ca[31:0];
            pll_b_reg <= kb_reg[31:0] * cb[31:0];
            plh_b_reg <= kb_reg[31:0] * cb[63:32];
            phl_b_reg <= kb_reg[63:32] * cb[31:0];
        end
    end

    assign stat.full = full_reg;
    assign stat.last = last_reg;
    assign out_word  = out_reg;

endmodule

// File: rtl/mmh3_ctrl.sv
// Controller of the MurmurHash3 x64 128-bit engine: sequences body, tail and finalizer steps.
// Drives mmh3_datapath through cmd_t; depends on mmh3_pkg.
`timescale 1ns / 1ps

module mmh3_ctrl
    import mmh3_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_KM1   = 5'd1;
    localparam logic [4:0] ST_KM1W  = 5'd2;
    localparam logic [4:0] ST_KROT  = 5'd3;
    localparam logic [4:0] ST_KM2   = 5'd4;
    localparam logic [4:0] ST_KM2W  = 5'd5;
    localparam logic [4:0] ST_H1MIX = 5'd6;
    localparam logic [4:0] ST_H1SCL = 5'd7;
    localparam logic [4:0] ST_H2MIX = 5'd8;
    localparam logic [4:0] ST_H2SCL = 5'd9;
    localparam logic [4:0] ST_TAIL  = 5'd10;
    localparam logic [4:0] ST_FOLD  = 5'd11;
    localparam logic [4:0] ST_ADD1  = 5'd12;
    localparam logic [4:0] ST_ADD2  = 5'd13;
    localparam logic [4:0] ST_XS0   = 5'd14;
    localparam logic [4:0] ST_FM1   = 5'd15;
    localparam logic [4:0] ST_FM1W  = 5'd16;
    localparam logic [4:0] ST_XS1   = 5'd17;
    localparam logic [4:0] ST_FM2   = 5'd18;
    localparam logic [4:0] ST_FM2W  = 5'd19;
    localparam logic [4:0] ST_XS2   = 5'd20;
    localparam logic [4:0] ST_SUM   = 5'd21;
    localparam logic [4:0] ST_OUT   = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // State transitions and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_KM1;
                end
            end
            ST_KM1: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_KEY_A;
                state_next    = ST_KM1W;
            end
            ST_KM1W: begin
                cmd.mul_write = 1'b1;
                state_next    = ST_KROT;
            end
            ST_KROT: begin
                cmd.rot_keys = 1'b1;
                state_next   = ST_KM2;
            end
            ST_KM2: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_KEY_B;
                state_next    = ST_KM2W;
            end
            ST_KM2W: begin
                cmd.mul_write = 1'b1;
                state_next    = stat.full ? ST_H1MIX : ST_TAIL;
            end
            ST_H1MIX: begin
                cmd.mix_one = 1'b1;
                state_next  = ST_H1SCL;
            end
            ST_H1SCL: begin
                cmd.scale_one = 1'b1;
                state_next    = ST_H2MIX;
            end
            ST_H2MIX: begin
                cmd.mix_two = 1'b1;
                state_next  = ST_H2SCL;
            end
            ST_H2SCL: begin
                cmd.scale_two = 1'b1;
                state_next    = stat.last ? ST_FOLD : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.tail_mix = 1'b1;
                state_next   = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold_len = 1'b1;
                state_next   = ST_ADD1;
            end
            ST_ADD1: begin
                cmd.add_one = 1'b1;
                state_next  = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.add_two = 1'b1;
                state_next  = ST_XS0;
            end
            ST_XS0: begin
                cmd.xs_lanes = 1'b1;
                state_next   = ST_FM1;
            end
            ST_FM1: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_FIN_A;
                state_next    = ST_FM1W;
            end
            ST_FM1W: begin
                cmd.mul_write = 1'b1;
                state_next    = ST_XS1;
            end
            ST_XS1: begin
                cmd.xs_keys = 1'b1;
                state_next  = ST_FM2;
            end
            ST_FM2: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_sel   = MUL_FIN_B;
                state_next    = ST_FM2W;
            end
            ST_FM2W: begin
                cmd.mul_write = 1'b1;
                state_next    = ST_XS2;
            end
            ST_XS2: begin
                cmd.xs_keys = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_lanes = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the word is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/murmur3_x64_128_hash_engine_core.sv
// MurmurHash3 x64 128-bit engine, top level: one 16-byte word per accept, 128-bit hash out.
// A new word is accepted only once the previous one is fully processed; the pace is set by the
// two 64-bit multiplies of the key mix, done on the shared multiply units, and the serial lane
// recurrence. A last word also runs the tail and finalizer steps, and its hash appears once the
// output register is free. Synchronous active-low reset clears the seed to zero, the length
// and the output valid, and marks the next word as a message start.
`timescale 1ns / 1ps

module murmur3_x64_128_hash_engine_core
    import mmh3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    mmh3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Lanes, keys and multiply units.
    mmh3_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_word     (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_word    (m_data)
    );

endmodule

// File: rtl/mmh3_checker.sv
// Port-level checker for the MurmurHash3 x64 128-bit engine, bound to the top level.
// Depends on mmh3_pkg.
`timescale 1ns / 1ps

module mmh3_checker
    import mmh3_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // After reset no result word is shown.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The engine works on one word at a time, so an accept is never directly followed by another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accept");

    // A new result is only produced as the engine returns to accepting.
    a_result_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result shown while engine busy");

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

endmodule

bind murmur3_x64_128_hash_engine_core mmh3_checker u_mmh3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: dv/murmur3_x64_128_hash_engine_core_tb.sv
// Self-checking testbench for the MurmurHash3 x64 128-bit hash engine core.
// Drives directed and random messages under several seeds and checks each hash against a
// predictor written in this file or a typed-in table hash. Depends on mmh3_pkg and murmur3_x64_128_hash_engine_core.
`timescale 1ns / 1ps

module murmur3_x64_128_hash_engine_core_tb;

    import mmh3_pkg::in_word_t;
    import mmh3_pkg::out_word_t;

    localparam logic [63:0] ALL_ONES     = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] KEY_MUL_A    = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] KEY_MUL_B    = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] LANE_A_BIAS  = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] LANE_B_BIAS  = 64'h0000_0000_3849_5ab5;
    localparam logic [63:0] AVAL_MUL_A   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] AVAL_MUL_B   = 64'hc4ce_b9fe_1a85_ec53;
    localparam int          PHASE_WORDS  = 180;
    localparam int          SETTLE_TICKS = 30;
    localparam int          DRAIN_TICKS  = 40;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_LIMIT = 10;
    localparam int          ROW_COUNT    = 21;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_LONG_STALL
    } stall_mode_t;

    // One row of the directed table: the word, and a hash typed in where it is obvious.
    typedef struct {
        in_word_t  word;
        bit        known;
        out_word_t hash;
    } row_t;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_word_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_word_t m_data;

    // Predictor state.
    logic [63:0] seed_value;
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [31:0] bytes_seen;
    bit          fresh_message;

    out_word_t   pending_hashes [$];
    out_word_t   oldest_hash;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          burst_left     = 0;
    int          phase_words    = 0;
    stall_mode_t stall_mode     = READY_ALWAYS;
    int          stall_left     = 0;
    int          stall_tick     = 0;

    // Directed words, sent after reset with the seed at its reset value of zero.
    row_t directed_rows [ROW_COUNT] = '{
        // Empty message: the hash of nothing under a zero seed is all zeros.
        '{'{64'hdead_beef_0123_4567, ALL_ONES, 5'd0, 1'b1}, 1'b1, '{64'h0, 64'h0}},
        // Short tails with every byte beyond the count set.
        '{'{ALL_ONES, ALL_ONES, 5'd1,  1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{ALL_ONES, ALL_ONES, 5'd7,  1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{ALL_ONES, ALL_ONES, 5'd8,  1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{ALL_ONES, ALL_ONES, 5'd9,  1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{ALL_ONES, ALL_ONES, 5'd15, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        // Single full block as the last word.
        '{'{ALL_ONES, ALL_ONES, 5'd16, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{64'h0, 64'h0, 5'd16, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        // Counts above sixteen saturate.
        '{'{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd31, 1'b1},
          1'b0, '{64'h0, 64'h0}},
        '{'{64'h0, 64'h0, 5'd17, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        // Two full blocks and an empty tail.
        '{'{ALL_ONES, ALL_ONES, 5'd16, 1'b0}, 1'b0, '{64'h0, 64'h0}},
        '{'{64'h0, 64'h0, 5'd16, 1'b0}, 1'b0, '{64'h0, 64'h0}},
        '{'{64'h0, 64'h0, 5'd0, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        // Body words with odd counts still count as full blocks.
        '{'{64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 5'd0, 1'b0},
          1'b0, '{64'h0, 64'h0}},
        '{'{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd31, 1'b0},
          1'b0, '{64'h0, 64'h0}},
        '{'{64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 5'd12, 1'b1},
          1'b0, '{64'h0, 64'h0}},
        // Full block followed by a full last block.
        '{'{ALL_ONES, ALL_ONES, 5'd16, 1'b0}, 1'b0, '{64'h0, 64'h0}},
        '{'{ALL_ONES, ALL_ONES, 5'd16, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 5'd5, 1'b0},
          1'b0, '{64'h0, 64'h0}},
        '{'{64'h0, 64'h0, 5'd1, 1'b1}, 1'b0, '{64'h0, 64'h0}},
        '{'{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 5'd8, 1'b1},
          1'b0, '{64'h0, 64'h0}}
    };

    murmur3_x64_128_hash_engine_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [63:0] rotate_left(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] v);
        v ^= v >> 33;
        v = v * AVAL_MUL_A;
        v ^= v >> 33;
        v = v * AVAL_MUL_B;
        v ^= v >> 33;
        return v;
    endfunction

    function automatic logic [63:0] scramble_low(input logic [63:0] k);
        k = k * KEY_MUL_A;
        k = rotate_left(k, 31);
        return k * KEY_MUL_B;
    endfunction

    function automatic logic [63:0] scramble_high(input logic [63:0] k);
        k = k * KEY_MUL_B;
        k = rotate_left(k, 33);
        return k * KEY_MUL_A;
    endfunction

    function automatic logic [63:0] keep_bytes(input int unsigned n);
        if (n >= 8) begin
            return ALL_ONES;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // One two-lane body round over a 16-byte block.
    function automatic void mix_block(input logic [63:0] lo, input logic [63:0] hi);
        lane_a ^= scramble_low(lo);
        lane_a = rotate_left(lane_a, 27);
        lane_a += lane_b;
        lane_a = lane_a * 5 + LANE_A_BIAS;
        lane_b ^= scramble_high(hi);
        lane_b = rotate_left(lane_b, 31);
        lane_b += lane_a;
        lane_b = lane_b * 5 + LANE_B_BIAS;
    endfunction

    // Absorbs one word into the running hash; returns 1 with the hash when the message ends.
    function automatic bit absorb_word(input in_word_t w, output out_word_t h);
        logic [63:0] k_lo;
        logic [63:0] k_hi;
        int unsigned n;
        h = '0;
        if (fresh_message) begin
            lane_a        = seed_value;
            lane_b        = seed_value;
            bytes_seen    = '0;
            fresh_message = 1'b0;
        end
        if (!w.last) begin
            mix_block(w.bytes_low, w.bytes_high);
            bytes_seen += 32'd16;
            return 1'b0;
        end
        n = (w.byte_count > 5'd16) ? 16 : int'(w.byte_count);
        if (n == 16) begin
            mix_block(w.bytes_low, w.bytes_high);
        end else begin
            k_lo = w.bytes_low & keep_bytes(n);
            k_hi = (n > 8) ? (w.bytes_high & keep_bytes(n - 8)) : 64'h0;
            lane_b ^= scramble_high(k_hi);
            lane_a ^= scramble_low(k_lo);
        end
        bytes_seen += 32'(n);
        // Length fold and finalizer.
        lane_a ^= {32'h0, bytes_seen};
        lane_b ^= {32'h0, bytes_seen};
        lane_a += lane_b;
        lane_b += lane_a;
        lane_a = avalanche(lane_a);
        lane_b = avalanche(lane_b);
        lane_a += lane_b;
        lane_b += lane_a;
        h.hash_first  = lane_a;
        h.hash_second = lane_b;
        fresh_message = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [63:0] random_lane();
        return {$urandom, $urandom};
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Sends one word in bursts with random gaps, then predicts its effect once accepted.
    task automatic send_word(input in_word_t w, input bit known, input out_word_t known_hash);
        int        gap;
        bit        done;
        out_word_t predicted;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        phase_words++;
        done = absorb_word(w, predicted);
        if (done) begin
            pending_hashes.push_back(known ? known_hash : predicted);
        end
    endtask

    // One message of random content: mostly full body words, a few short ones as noise, and a last word.
    task automatic send_message();
        in_word_t w;
        int       body_words;
        int       pick;
        pick = $urandom_range(0, 9);
        body_words = (pick < 6) ? $urandom_range(0, 3) :
                     (pick < 9) ? $urandom_range(4, 10) : $urandom_range(11, 40);
        repeat (body_words) begin
            w.bytes_low  = random_lane();
            w.bytes_high = random_lane();
            w.byte_count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
            w.last       = 1'b0;
            send_word(w, 1'b0, '0);
        end
        pick = $urandom_range(0, 9);
        w.bytes_low  = random_lane();
        w.bytes_high = random_lane();
        w.byte_count = (pick < 8) ? 5'($urandom_range(0, 16)) :
                       (pick < 9) ? 5'd16 : 5'($urandom_range(17, 31));
        w.last       = 1'b1;
        send_word(w, 1'b0, '0);
    endtask

    // Lets the engine drain fully, then loads a new seed.
    task automatic load_seed(input logic [63:0] seed);
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_hashes.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        seed_value = seed;
    endtask

    // Result receiver: the stall pattern is redrawn whenever its random run length expires.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            READY_ALWAYS:     m_ready <= 1'b1;
            READY_COIN:       m_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC:   m_ready <= (stall_tick % 7) >= 3;
            READY_LONG_STALL: m_ready <= (stall_tick % 25) >= 20;
            default:          m_ready <= 1'b1;
        endcase
    end

    // Compare every accepted hash with the oldest one expected.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                note_mismatch("unexpected hash_first", 64'h0, m_data.hash_first);
            end else begin
                oldest_hash = pending_hashes.pop_front();
                if (m_data.hash_first !== oldest_hash.hash_first) begin
                    note_mismatch("hash_first", oldest_hash.hash_first, m_data.hash_first);
                end
                if (m_data.hash_second !== oldest_hash.hash_second) begin
                    note_mismatch("hash_second", oldest_hash.hash_second, m_data.hash_second);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[murmur3_x64_128_hash_engine_core] ERROR");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases under several seeds.
    initial begin
        logic [63:0] phase_seeds [6];
        seed_value    = '0;
        lane_a        = '0;
        lane_b        = '0;
        bytes_seen    = '0;
        fresh_message = 1'b1;
        phase_seeds   = '{64'h0, ALL_ONES, random_lane(), 64'h1,
                          64'h8000_0000_0000_0000, random_lane()};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].hash);
        end

        foreach (phase_seeds[p]) begin
            load_seed(phase_seeds[p]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) send_message();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
        if (mismatch_count == 0 && pending_hashes.size() == 0) begin
            $display("[murmur3_x64_128_hash_engine_core] OK");
        end else begin
            $display("[murmur3_x64_128_hash_engine_core] ERROR");
        end
        $finish;
    end

endmodule

// File: murmur3_x64_128_hash_engine_core.f
rtl/mmh3_pkg.sv
rtl/mmh3_datapath.sv
rtl/mmh3_ctrl.sv
rtl/murmur3_x64_128_hash_engine_core.sv
rtl/mmh3_checker.sv
dv/murmur3_x64_128_hash_engine_core_tb.sv
